[sv/peak_normalize_audio_buffer_defines.svh]
// Assertion helpers used by the checker file
`ifndef PEAK_NORMALIZE_AUDIO_BUFFER_DEFINES_SVH
`define PEAK_NORMALIZE_AUDIO_BUFFER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define PNAB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define PNAB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/pnab_pkg.sv]
package pnab_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 14;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 14'd8192;

    // Shift-subtract divider: one quotient bit per step
    localparam int DIV_STEPS = 15;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [SAMPLE_W-1:0] POS_FULL = 16'h7fff;
    localparam logic [SAMPLE_W-1:0] NEG_FULL = 16'h8000;

    // Input item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Configuration register indexes
    localparam logic REG_WORD_MODE    = 1'b0;
    localparam logic REG_SAMPLE_COUNT = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_READY = 2'd1;
    localparam logic [1:0] ST_SAT       = 2'd2;
    localparam logic [1:0] ST_PASS      = 2'd3;

endpackage

[sv/peak_normalize_audio_buffer.sv]
// Records one mono buffer of up to MAX_SAMPLES 16-bit samples taken from the
// upper half of raw I2S words (in word_mode 1 every second word is dropped),
// tracking the largest sample value. Once sample_count samples are stored,
// each read transaction returns the next sample scaled by 32768/peak,
// truncated toward zero and saturated to 16 bits (status 2), or unchanged if
// the peak is not positive (status 3); a read before the buffer is full
// returns status 1. After the sample flagged tlast the buffer rearms for a
// new recording. A load does not hold the input side. A read holds the
// input side while it goes through the divider (accept, memory fetch, 15
// shift-subtract steps, hand-off to the output register); the saturated and
// passthrough paths skip the steps, and a read before the buffer is full
// also skips the fetch. The output register lets a result wait while the
// next item is accepted; a stalled output delays only the next read's
// hand-off. Configuration writes are taken in every cycle.
module peak_normalize_audio_buffer
    import pnab_pkg::*;
#(
    parameter int MAX_SAMPLES = 8192
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input stream
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [31:0]         i_s_tdata,   // [31:0] raw_word
    input  logic                i_s_tuser,   // [0] kind
    // Output stream
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [SAMPLE_W-1:0] o_m_tdata,   // [15:0] sample_out
    output logic                o_m_tlast,
    output logic [1:0]          o_m_tuser,   // [1:0] status
    // Configuration writes
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [COUNT_W-1:0]  i_cfg_data
);

    localparam int ADDR_W = $clog2(MAX_SAMPLES);
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_SAMPLES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_DIV,
        S_DONE
    } t_state;

    t_state                    r_state;
    logic                      r_word_mode;
    logic [COUNT_W-1:0]        r_sample_count;
    logic [CNT_W-1:0]          r_write_index;
    logic [ADDR_W-1:0]         r_read_index;
    logic signed [SAMPLE_W-1:0] r_peak;
    logic                      r_skip;
    logic [SAMPLE_W-1:0]       r_store [MAX_SAMPLES];
    logic [SAMPLE_W-1:0]       r_rd_q;
    logic                      r_res_neg;
    logic [SAMPLE_W-1:0]       r_res_mag;
    logic [1:0]                r_res_status;
    logic                      r_res_last;
    logic                      r_upd;
    logic [SAMPLE_W-2:0]       r_rem;
    logic [STEP_W-1:0]         r_step;
    logic                      r_m_tvalid;
    logic [SAMPLE_W-1:0]       r_m_tdata;
    logic                      r_m_tlast;
    logic [1:0]                r_m_tuser;

    logic [CMP_W-1:0]          cnt_ext;
    logic [CMP_W-1:0]          eff_count;
    logic                      rec_done;
    logic                      rd_last;
    logic                      in_acc;
    logic                      keep;
    logic                      store_we;
    logic signed [SAMPLE_W-1:0] in_sample;
    logic                      s_neg;
    logic [SAMPLE_W-1:0]       s_mag;
    logic [SAMPLE_W-1:0]       peak_ext;
    logic                      peak_pos;
    logic [SAMPLE_W-1:0]       shifted;
    logic                      div_ge;
    logic [SAMPLE_W-1:0]       div_diff;
    logic                      out_free;

    // Clamp the sample count to 1..MAX_SAMPLES
    always_comb begin
        cnt_ext = CMP_W'(r_sample_count);
        if (cnt_ext == '0) begin
            eff_count = CMP_W'(1);
        end else if (cnt_ext > MAX_CMP) begin
            eff_count = MAX_CMP;
        end else begin
            eff_count = cnt_ext;
        end
    end

    assign rec_done = CMP_W'(r_write_index) >= eff_count;
    assign rd_last  = (CMP_W'(r_read_index) + CMP_W'(1)) >= eff_count;

    // Load path decode
    assign in_acc    = i_s_tvalid && o_s_tready;
    assign keep      = r_word_mode ? !r_skip : 1'b1;
    assign in_sample = signed'(i_s_tdata[31:16]);
    assign store_we  = in_acc && (i_s_tuser == KIND_LOAD) && !rec_done && keep;

    // Sample magnitude and peak for the scaling decision
    assign s_neg    = r_rd_q[SAMPLE_W-1];
    assign s_mag    = s_neg ? (~r_rd_q + SAMPLE_W'(1)) : r_rd_q;
    assign peak_ext = unsigned'(r_peak);
    assign peak_pos = !r_peak[SAMPLE_W-1] && (r_peak != '0);

    // One restoring-division step
    assign shifted  = {r_rem, 1'b0};
    assign div_ge   = shifted >= peak_ext;
    assign div_diff = shifted - peak_ext;

    assign out_free = !r_m_tvalid || i_m_tready;

    // Sample memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_write_index[ADDR_W-1:0]] <= unsigned'(in_sample);
        end
        r_rd_q <= r_store[r_read_index];
    end

    // Sequencer, recording state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_word_mode    <= 1'b0;
            r_sample_count <= COUNT_RESET;
            r_write_index  <= '0;
            r_read_index   <= '0;
            r_peak         <= '0;
            r_skip         <= 1'b0;
            r_m_tvalid     <= 1'b0;
        end else begin
            // Configuration writes
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_WORD_MODE:    r_word_mode    <= i_cfg_data[0];
                    REG_SAMPLE_COUNT: r_sample_count <= i_cfg_data;
                endcase
            end

            // Drop the result once the downstream takes it; S_DONE loads the next one
            if (i_m_tready && (r_state != S_DONE)) begin
                r_m_tvalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_s_tuser == KIND_LOAD) begin
                            if (!rec_done) begin
                                r_skip <= r_word_mode ? !r_skip : 1'b0;
                                if (keep) begin
                                    r_write_index <= r_write_index + CNT_W'(1);
                                    if (in_sample > r_peak) begin
                                        r_peak <= in_sample;
                                    end
                                end
                            end
                        end else if (!rec_done) begin
                            r_res_neg    <= 1'b0;
                            r_res_mag    <= '0;
                            r_res_status <= ST_NOT_READY;
                            r_res_last   <= 1'b0;
                            r_upd        <= 1'b0;
                            r_state      <= S_DONE;
                        end else begin
                            r_res_last <= rd_last;
                            r_upd      <= 1'b1;
                            r_state    <= S_FETCH;
                        end
                    end
                end

                S_FETCH: begin
                    if (!peak_pos) begin
                        r_res_neg    <= 1'b0;
                        r_res_mag    <= r_rd_q;
                        r_res_status <= ST_PASS;
                        r_state      <= S_DONE;
                    end else if (s_mag >= peak_ext) begin
                        // Quotient reaches 32768: only minus full scale fits
                        r_res_neg <= s_neg;
                        if (s_neg) begin
                            r_res_mag    <= NEG_FULL;
                            r_res_status <= (s_mag == peak_ext) ? ST_OK : ST_SAT;
                        end else begin
                            r_res_mag    <= POS_FULL;
                            r_res_status <= ST_SAT;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_res_neg    <= s_neg;
                        r_res_mag    <= '0;
                        r_res_status <= ST_OK;
                        r_rem        <= s_mag[SAMPLE_W-2:0];
                        r_step       <= '0;
                        r_state      <= S_DIV;
                    end
                end

                S_DIV: begin
                    r_res_mag <= {r_res_mag[SAMPLE_W-2:0], div_ge};
                    r_rem     <= div_ge ? div_diff[SAMPLE_W-2:0] : shifted[SAMPLE_W-2:0];
                    r_step    <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                        r_state <= S_DONE;
                    end
                end

                S_DONE: begin
                    if (out_free) begin
                        r_m_tvalid <= 1'b1;
                        r_m_tdata  <= r_res_neg ? (~r_res_mag + SAMPLE_W'(1)) : r_res_mag;
                        r_m_tlast  <= r_res_last;
                        r_m_tuser  <= r_res_status;
                        // Advance read-out, or rearm after the final sample
                        if (r_upd) begin
                            if (r_res_last) begin
                                r_write_index <= '0;
                                r_read_index  <= '0;
                                r_peak        <= '0;
                                r_skip        <= 1'b0;
                            end else begin
                                r_read_index <= r_read_index + ADDR_W'(1);
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_m_tvalid;
    assign o_m_tdata   = r_m_tdata;
    assign o_m_tlast   = r_m_tlast;
    assign o_m_tuser   = r_m_tuser;

endmodule

[sv/pnab_checker.sv]
`include "peak_normalize_audio_buffer_defines.svh"

module pnab_checker
    import pnab_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_tvalid,
    input logic                o_s_tready,
    input logic [31:0]         i_s_tdata,   // [31:0] raw_word
    input logic                i_s_tuser,   // [0] kind
    input logic                o_m_tvalid,
    input logic                i_m_tready,
    input logic [SAMPLE_W-1:0] o_m_tdata,   // [15:0] sample_out
    input logic                o_m_tlast,
    input logic [1:0]          o_m_tuser,   // [1:0] status
    input logic                i_cfg_valid,
    input logic                o_cfg_ready,
    input logic                i_cfg_index,
    input logic [COUNT_W-1:0]  i_cfg_data
);

    // Hold a stalled result
    `PNAB_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "result dropped or changed while stalled")

    // A read transaction keeps the input side busy in the next cycle
    `PNAB_ASSERT_NEXT(a_read_busy, i_s_tvalid && o_s_tready && (i_s_tuser == KIND_READ), !o_s_tready, "input ready right after a read transaction")

    // An early read returns zero and is never the final sample
    `PNAB_ASSERT_NOW(a_not_ready_zero, o_m_tvalid && (o_m_tuser == ST_NOT_READY), (o_m_tdata == '0) && !o_m_tlast, "early read result not zero")

    // A saturated result sits on a rail
    `PNAB_ASSERT_NOW(a_sat_rail, o_m_tvalid && (o_m_tuser == ST_SAT), (o_m_tdata == POS_FULL) || (o_m_tdata == NEG_FULL), "saturated result off the rails")

endmodule

bind peak_normalize_audio_buffer pnab_checker u_pnab_checker (.*);

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
    import pnab_pkg::*;

    localparam int BUF_DEPTH   = 8192;
    localparam int SETTLE_CYC  = 30;
    localparam int DRAIN_CYC   = 60;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int RAND_ITEMS  = 1200;

    typedef enum logic [1:0] {OP_STREAM, OP_REG_WRITE, OP_QUIESCE} op_e;

    typedef struct packed {
        op_e                op;
        logic               kind;
        logic [31:0]        word;
        logic               idx;
        logic [COUNT_W-1:0] val;
    } bus_op_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] pcm;
        logic                fin;
        logic [1:0]          code;
    } norm_res_t;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_s_tvalid  = 1'b0;
    logic                o_s_tready;
    logic [31:0]         i_s_tdata   = '0;
    logic                i_s_tuser   = 1'b0;
    logic                o_m_tvalid;
    logic                i_m_tready  = 1'b0;
    logic [SAMPLE_W-1:0] o_m_tdata;
    logic                o_m_tlast;
    logic [1:0]          o_m_tuser;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic                i_cfg_index = 1'b0;
    logic [COUNT_W-1:0]  i_cfg_data  = '0;

    // Stimulus and scoreboard state
    bus_op_t   bus_ops[$];
    norm_res_t pending_samples[$];
    bit        drive_en   = 1'b0;
    bit        s_fire     = 1'b0;
    bit        cfg_fire   = 1'b0;
    bit        calm       = 1'b0;
    int        gap_left   = 0;
    int        stall_left = 0;
    int        settle_cnt = 0;
    int        errors     = 0;
    int        n_items    = 0;
    int        cycles     = 0;
    logic      gen_mode   = 1'b0;

    // Shadow copy of the buffer, peak tracker and registers
    logic signed [SAMPLE_W-1:0] shadow_buf [0:BUF_DEPTH-1];
    logic signed [SAMPLE_W-1:0] shadow_peak = '0;
    int unsigned                wr_ptr      = 0;
    int unsigned                rd_ptr      = 0;
    logic                       odd_slot    = 1'b0;
    logic                       shadow_mode = 1'b0;
    logic [COUNT_W-1:0]         shadow_cnt  = COUNT_RESET;

    peak_normalize_audio_buffer #(
        .MAX_SAMPLES(BUF_DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Mostly short gaps, a few long ones, none while calm
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Raw I2S word whose upper half follows the chosen sample flavor
    function automatic logic [31:0] make_word(input int style);
        logic [31:0] w;
        w = $urandom;
        case (style)
            1: w[31] = 1'b1;
            2: w[31:16] = 16'($urandom_range(0, 255)) - 16'd128;
            3: begin
                case ($urandom_range(0, 4))
                    0: w[31:16] = POS_FULL;
                    1: w[31:16] = NEG_FULL;
                    2: w[31:16] = 16'h0000;
                    3: w[31:16] = 16'hffff;
                    default: w[31:16] = 16'h0001;
                endcase
            end
            default: ;
        endcase
        return w;
    endfunction

    // Advance the shadow buffer by one accepted transaction
    task automatic normalize_step(input logic kind, input logic [31:0] word);
        int unsigned                lim;
        logic signed [SAMPLE_W-1:0] smp;
        bit                         keep;
        bit                         fin;
        longint                     q;
        norm_res_t                  res;
        lim = (shadow_cnt == 0) ? 1 : ((shadow_cnt > BUF_DEPTH) ? BUF_DEPTH : shadow_cnt);
        if (kind == KIND_LOAD) begin
            // Loads after the buffer is full are dropped
            if (wr_ptr < lim) begin
                keep = 1'b1;
                if (shadow_mode) begin
                    keep     = !odd_slot;
                    odd_slot = !odd_slot;
                end else begin
                    odd_slot = 1'b0;
                end
                if (keep) begin
                    smp                = word[31:16];
                    shadow_buf[wr_ptr] = smp;
                    if (smp > shadow_peak) shadow_peak = smp;
                    wr_ptr++;
                end
            end
        end else if (wr_ptr < lim) begin
            res.pcm  = '0;
            res.fin  = 1'b0;
            res.code = ST_NOT_READY;
            pending_samples.push_back(res);
        end else begin
            smp = (rd_ptr < BUF_DEPTH) ? shadow_buf[rd_ptr] : '0;
            fin = (rd_ptr + 1 >= lim);
            if (shadow_peak <= 0) begin
                res.pcm  = smp;
                res.code = ST_PASS;
            end else begin
                q        = (longint'(smp) * 32768) / longint'(shadow_peak);
                res.code = ST_OK;
                if (q > 32767) begin
                    q        = 32767;
                    res.code = ST_SAT;
                end
                if (q < -32768) begin
                    q        = -32768;
                    res.code = ST_SAT;
                end
                res.pcm = q[SAMPLE_W-1:0];
            end
            res.fin = fin;
            pending_samples.push_back(res);
            // Rearm after the final sample of the recording
            if (fin) begin
                wr_ptr      = 0;
                rd_ptr      = 0;
                shadow_peak = '0;
                odd_slot    = 1'b0;
            end else begin
                rd_ptr++;
            end
        end
    endtask

    task automatic put_item(input logic kind, input logic [31:0] word);
        bus_op_t o;
        o.op   = OP_STREAM;
        o.kind = kind;
        o.word = word;
        o.idx  = 1'b0;
        o.val  = '0;
        bus_ops.push_back(o);
        n_items++;
    endtask

    // Register writes only go out once the block is idle
    task automatic put_reg(input logic idx, input logic [COUNT_W-1:0] val);
        bus_op_t o;
        o.op   = OP_QUIESCE;
        o.kind = 1'b0;
        o.word = '0;
        o.idx  = idx;
        o.val  = val;
        bus_ops.push_back(o);
        o.op = OP_REG_WRITE;
        bus_ops.push_back(o);
        if (idx == REG_WORD_MODE) gen_mode = val[0];
    endtask

    task automatic random_phase();
        int r;
        int cnt;
        int eff;
        int loads;
        int style;
        int half;
        int recnt;
        r = $urandom_range(0, 99);
        if (r < 4) cnt = 0;
        else if (r < 70) cnt = $urandom_range(1, 8);
        else if (r < 94) cnt = $urandom_range(9, 32);
        else cnt = $urandom_range(33, 96);
        eff   = (cnt == 0) ? 1 : cnt;
        style = $urandom_range(0, 3);
        if ($urandom_range(0, 2) == 0) put_reg(REG_WORD_MODE, COUNT_W'($urandom_range(0, 1)));
        put_reg(REG_SAMPLE_COUNT, COUNT_W'(cnt));
        loads = eff * (gen_mode ? 2 : 1) + $urandom_range(0, 1);
        // Now and then cut the recording short
        if ($urandom_range(0, 19) == 0) loads = $urandom_range(0, loads);
        for (int i = 0; i < loads; i++) begin
            if ($urandom_range(0, 19) == 0) put_item(KIND_READ, $urandom);
            put_item(KIND_LOAD, make_word(style));
        end
        // Change the count halfway through read-out on some phases
        if (eff > 2 && $urandom_range(0, 9) == 0) begin
            half = eff / 2;
            for (int i = 0; i < half; i++) put_item(KIND_READ, $urandom);
            recnt = $urandom_range(1, eff + 4);
            put_reg(REG_SAMPLE_COUNT, COUNT_W'(recnt));
            for (int i = 0; i < recnt * (gen_mode ? 2 : 1); i++)
                put_item(KIND_LOAD, make_word(style));
            for (int i = 0; i < recnt; i++) put_item(KIND_READ, $urandom);
        end else begin
            for (int i = 0; i < eff; i++) put_item(KIND_READ, $urandom);
        end
        if ($urandom_range(0, 9) == 0) put_item(KIND_READ, $urandom);
    endtask

    // Count all ones clamps to the buffer depth; the recording stays incomplete
    task automatic deep_count_phase();
        put_reg(REG_WORD_MODE, COUNT_W'(0));
        put_reg(REG_SAMPLE_COUNT, '1);
        for (int i = 0; i < 8; i++) put_item(KIND_LOAD, make_word(0));
        for (int i = 0; i < 2; i++) put_item(KIND_READ, $urandom);
    endtask

    // Stimulus, reset and end of run
    initial begin
        bit big_done;
        big_done = 1'b0;

        // Reset values: every word kept, full-size count
        put_item(KIND_READ, $urandom);
        put_item(KIND_LOAD, 32'h8000_0000);
        put_item(KIND_LOAD, 32'h7fff_ffff);
        put_reg(REG_SAMPLE_COUNT, COUNT_W'(3));
        put_item(KIND_LOAD, 32'h0001_abcd);
        put_item(KIND_LOAD, 32'h7fff_0000);
        for (int i = 0; i < 3; i++) put_item(KIND_READ, $urandom);
        // Zero count acts as one; a negative sample leaves the peak at zero, so samples pass through
        put_reg(REG_WORD_MODE, COUNT_W'(1));
        put_reg(REG_SAMPLE_COUNT, COUNT_W'(0));
        put_item(KIND_LOAD, 32'hffff_1234);
        put_item(KIND_LOAD, 32'h7fff_0000);
        put_item(KIND_READ, $urandom);
        // Odd word dropped in 32-bit slot mode
        put_reg(REG_SAMPLE_COUNT, COUNT_W'(2));
        put_item(KIND_LOAD, 32'h0100_0000);
        put_item(KIND_LOAD, 32'h7fff_ffff);
        put_item(KIND_LOAD, 32'hff80_5555);
        put_item(KIND_READ, $urandom);
        put_item(KIND_READ, $urandom);
        // Zero peak
        put_reg(REG_SAMPLE_COUNT, COUNT_W'(1));
        put_item(KIND_LOAD, 32'h0000_ffff);
        put_item(KIND_READ, $urandom);

        while (n_items < RAND_ITEMS) begin
            if (!big_done && n_items > RAND_ITEMS / 2) begin
                deep_count_phase();
                big_done = 1'b1;
            end
            random_phase();
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  <= 1'b1;
        drive_en <= 1'b1;

        while (bus_ops.size() > 0 || i_s_tvalid || i_cfg_valid || pending_samples.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (pending_samples.size() > 0) begin
            $display("%0t: %0d results never arrived", $time, pending_samples.size());
            errors++;
        end
        if (errors == 0) begin
            $display("peak_normalize_audio_buffer: match");
        end else begin
            $display("peak_normalize_audio_buffer: mismatch");
        end
        $finish;
    end

    // Cycle limit and calm-stretch toggling
    always @(posedge i_clk) begin
        cycles++;
        if ($urandom_range(0, 399) == 0) calm = !calm;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("peak_normalize_audio_buffer: mismatch");
            $finish;
        end
    end

    // Input and register driver
    always @(negedge i_clk) begin : drive_proc
        logic    hold_s;
        logic    hold_c;
        bus_op_t head;
        if (drive_en) begin
            hold_s = i_s_tvalid && !s_fire;
            hold_c = i_cfg_valid && !cfg_fire;
            if (!hold_s && !hold_c && gap_left > 0) begin
                gap_left--;
            end else if (!hold_s && !hold_c && bus_ops.size() > 0) begin
                head = bus_ops[0];
                case (head.op)
                    OP_STREAM: begin
                        hold_s = 1'b1;
                        i_s_tdata <= head.word;
                        i_s_tuser <= head.kind;
                        head     = bus_ops.pop_front();
                        gap_left = pick_gap();
                    end
                    OP_REG_WRITE: begin
                        hold_c = 1'b1;
                        i_cfg_index <= head.idx;
                        i_cfg_data  <= head.val;
                        head = bus_ops.pop_front();
                    end
                    default: begin
                        // Wait out outstanding reads, then let the block settle
                        if (pending_samples.size() > 0) begin
                            settle_cnt = 0;
                        end else if (settle_cnt < SETTLE_CYC) begin
                            settle_cnt++;
                        end else begin
                            settle_cnt = 0;
                            head = bus_ops.pop_front();
                        end
                    end
                endcase
            end
            i_s_tvalid  <= hold_s;
            i_cfg_valid <= hold_c;
        end
    end

    // Output backpressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    // Monitor: track accepted transactions and check results
    always @(posedge i_clk) begin : mon_proc
        norm_res_t want;
        if (i_rst_n) begin
            s_fire   = i_s_tvalid && o_s_tready;
            cfg_fire = i_cfg_valid && o_cfg_ready;
            if (cfg_fire) begin
                if (i_cfg_index == REG_WORD_MODE) shadow_mode = i_cfg_data[0];
                else shadow_cnt = i_cfg_data;
            end
            if (s_fire) normalize_step(i_s_tuser, i_s_tdata);
            if (o_m_tvalid && i_m_tready) begin
                if (pending_samples.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual tdata=%h tlast=%b tuser=%0d",
                             $time, o_m_tdata, o_m_tlast, o_m_tuser);
                    errors++;
                end else begin
                    want = pending_samples.pop_front();
                    if (o_m_tdata !== want.pcm) begin
                        $display("%0t: sample_out expected %h actual %h", $time, want.pcm, o_m_tdata);
                        errors++;
                    end
                    if (o_m_tlast !== want.fin) begin
                        $display("%0t: last expected %b actual %b", $time, want.fin, o_m_tlast);
                        errors++;
                    end
                    if (o_m_tuser !== want.code) begin
                        $display("%0t: status expected %0d actual %0d", $time, want.code, o_m_tuser);
                        errors++;
                    end
                end
            end
        end else begin
            s_fire   = 1'b0;
            cfg_fire = 1'b0;
        end
    end

endmodule

[peak_normalize_audio_buffer.f]
+incdir+sv
sv/pnab_pkg.sv
sv/peak_normalize_audio_buffer.sv
sv/pnab_checker.sv
sim/tb.sv
